// ===== hdl/lrc_pkg.sv =====
package lrc_pkg;

  // cache geometry
  localparam int unsigned WAYS  = 5;
  localparam int unsigned IDX_W = $clog2(WAYS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WAYS - 1);

  // field widths
  localparam int unsigned VAR_W  = 10;
  localparam int unsigned IMM_W  = 16;
  localparam int unsigned CLS_W  = 2;
  localparam int unsigned SLOT_W = 8;

  // command codes
  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  // status codes
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_WR_IMM = 1'b1;

  // variable classes
  localparam logic [CLS_W-1:0] CLS_GLOBAL  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_INVALID = 2'd3;

  typedef struct packed {
    logic                     command;
    logic                     is_variable;
    logic [VAR_W-1:0]         var_id;
    logic signed [IMM_W-1:0]  imm_value;
    logic [CLS_W-1:0]         var_class;
    logic [SLOT_W-1:0]        stack_slot;
    logic                     write;
  } in_t;

  typedef struct packed {
    logic                status;
    logic [IDX_W-1:0]    reg_index;
    logic                hit;
    logic                load_valid;
    logic                spill_valid;
    logic [VAR_W-1:0]    spill_var_id;
    logic [CLS_W-1:0]    spill_class;
    logic [SLOT_W-1:0]   spill_slot;
    logic [IDX_W-1:0]    spill_reg;
    logic [WAYS-1:0]     used_mask;
    logic                last;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic             load_in;
    logic             age;
    logic             resolve;
    logic             flush_step;
    logic             emit_err;
    logic             emit_close;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic imm_write;
    logic flush_spill;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/lrc_ctrl.sv =====
module lrc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic          s_flush_i,
  output logic          s_ready_o,
  input  lrc_pkg::sts_t sts_i,
  output lrc_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AGE,
    S_RESOLVE,
    S_FLUSH,
    S_CLOSE
  } state_e;

  state_e                      state_q;
  logic [lrc_pkg::IDX_W-1:0]   idx_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.idx     = idx_q;
    s_ready_o     = (state_q == S_IDLE);
    cmd_o.load_in = s_ready_o && s_valid_i;
    case (state_q)
      S_AGE: begin
        if (sts_i.imm_write) begin
          cmd_o.emit_err = sts_i.out_free;
        end else begin
          cmd_o.age = 1'b1;
        end
      end
      S_RESOLVE: cmd_o.resolve    = sts_i.out_free;
      S_FLUSH:   cmd_o.flush_step = !sts_i.flush_spill || sts_i.out_free;
      S_CLOSE:   cmd_o.emit_close = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_valid_i) begin
            idx_q   <= '0;
            state_q <= (s_flush_i == lrc_pkg::CMD_FLUSH) ? S_FLUSH : S_AGE;
          end
        end
        S_AGE: begin
          if (!sts_i.imm_write) begin
            state_q <= S_RESOLVE;
          end else if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        S_RESOLVE: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (cmd_o.flush_step) begin
            if (idx_q == lrc_pkg::LAST_IDX) begin
              state_q <= S_CLOSE;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        S_CLOSE: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/lrc_dp.sv =====
module lrc_dp #(
  parameter int unsigned AGE_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lrc_pkg::in_t  in_i,
  input  lrc_pkg::cmd_t cmd_i,
  output lrc_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lrc_pkg::res_t out_o
);

  localparam int unsigned W = lrc_pkg::WAYS;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  // entry store
  logic [W-1:0]                       valid_q, is_imm_q, dirty_q;
  logic [AGE_BITS-1:0]                age_q   [W];
  logic [lrc_pkg::VAR_W-1:0]          var_q   [W];
  logic [lrc_pkg::IMM_W-1:0]          imm_q   [W];
  logic [lrc_pkg::CLS_W-1:0]          cls_q   [W];
  logic [lrc_pkg::SLOT_W-1:0]         slot_q  [W];
  logic [W-1:0]                       used_q;

  lrc_pkg::in_t  in_q, in_fold;
  lrc_pkg::res_t out_q, res_d;
  logic          out_valid_q;
  logic          emit;

  // lookup and victim pick
  logic [W-1:0]                match;
  logic                        found;
  logic [lrc_pkg::IDX_W-1:0]   hit_idx, vic_idx, tgt_idx;
  logic [AGE_BITS-1:0]         best;
  logic                        vic_spill;
  logic [W-1:0]                tgt_bit;

  // class three is kept as global
  always_comb begin
    in_fold = in_i;
    if (in_i.var_class == lrc_pkg::CLS_INVALID) begin
      in_fold.var_class = lrc_pkg::CLS_GLOBAL;
    end
  end

  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < W; i++) begin
      match[i] = valid_q[i] &&
                 (in_q.is_variable ? (!is_imm_q[i] && var_q[i] == in_q.var_id)
                                   : (is_imm_q[i] && imm_q[i] == in_q.imm_value));
      if (match[i] && !found) begin
        found   = 1'b1;
        hit_idx = lrc_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    best    = '0;
    vic_idx = '0;
    for (int i = 0; i < W; i++) begin
      if (age_q[i] > best) begin
        best    = age_q[i];
        vic_idx = lrc_pkg::IDX_W'(i);
      end
    end
  end

  assign tgt_idx   = found ? hit_idx : vic_idx;
  assign tgt_bit   = W'(1) << tgt_idx;
  assign vic_spill = valid_q[vic_idx] && dirty_q[vic_idx] && !is_imm_q[vic_idx];

  assign sts_o.imm_write   = !in_q.is_variable && in_q.write;
  assign sts_o.flush_spill = valid_q[cmd_i.idx] && !is_imm_q[cmd_i.idx] &&
                             dirty_q[cmd_i.idx] && cls_q[cmd_i.idx] == lrc_pkg::CLS_GLOBAL;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  // result beat
  always_comb begin
    res_d           = '0;
    res_d.used_mask = used_q;
    emit            = 1'b0;
    if (cmd_i.resolve) begin
      emit            = 1'b1;
      res_d.reg_index = tgt_idx;
      res_d.hit       = found;
      res_d.load_valid = !found;
      res_d.used_mask = used_q | tgt_bit;
      res_d.last      = 1'b1;
      if (!found && vic_spill) begin
        res_d.spill_valid  = 1'b1;
        res_d.spill_var_id = var_q[vic_idx];
        res_d.spill_class  = cls_q[vic_idx];
        res_d.spill_slot   = (cls_q[vic_idx] != lrc_pkg::CLS_GLOBAL) ? slot_q[vic_idx] : '0;
        res_d.spill_reg    = vic_idx;
      end
    end else if (cmd_i.emit_err) begin
      emit         = 1'b1;
      res_d.status = lrc_pkg::ST_WR_IMM;
      res_d.last   = 1'b1;
    end else if (cmd_i.emit_close) begin
      emit       = 1'b1;
      res_d.last = 1'b1;
    end else if (cmd_i.flush_step && sts_o.flush_spill) begin
      emit               = 1'b1;
      res_d.spill_valid  = 1'b1;
      res_d.spill_var_id = var_q[cmd_i.idx];
      res_d.spill_reg    = cmd_i.idx;
    end
  end

  // control state of the entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      is_imm_q    <= '0;
      dirty_q     <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < W; i++) begin
        age_q[i] <= AGE_MAX;
      end
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.age) begin
        for (int i = 0; i < W; i++) begin
          if (age_q[i] != AGE_MAX) begin
            age_q[i] <= age_q[i] + 1'b1;
          end
        end
      end
      if (cmd_i.resolve) begin
        age_q[tgt_idx] <= '0;
        used_q         <= used_q | tgt_bit;
        if (found) begin
          dirty_q[tgt_idx] <= dirty_q[tgt_idx] | in_q.write;
        end else begin
          valid_q[tgt_idx]  <= 1'b1;
          dirty_q[tgt_idx]  <= in_q.write;
          is_imm_q[tgt_idx] <= !in_q.is_variable;
        end
      end
      if (cmd_i.flush_step && valid_q[cmd_i.idx] && !is_imm_q[cmd_i.idx]) begin
        valid_q[cmd_i.idx] <= 1'b0;
        dirty_q[cmd_i.idx] <= 1'b0;
        age_q[cmd_i.idx]   <= AGE_MAX;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_fold;
    end
    if (emit) begin
      out_q <= res_d;
    end
    if (cmd_i.resolve && !found) begin
      if (in_q.is_variable) begin
        var_q[tgt_idx]  <= in_q.var_id;
        imm_q[tgt_idx]  <= '0;
        cls_q[tgt_idx]  <= in_q.var_class;
        slot_q[tgt_idx] <= in_q.stack_slot;
      end else begin
        var_q[tgt_idx]  <= '0;
        imm_q[tgt_idx]  <= in_q.imm_value;
        cls_q[tgt_idx]  <= lrc_pkg::CLS_GLOBAL;
        slot_q[tgt_idx] <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== hdl/lru_writeback_register_cache_top.sv =====
// access: aged in S_AGE, picked in S_RESOLVE, result registered; one request at a time
// immediate write error: error beat from S_AGE, registered, no aging; one request at a time
// flush: S_FLUSH walks all entries, S_CLOSE sends the closing beat; output stalls hold both
// the age pass and the lookup/lru pick run in separate states on the shared entry datapath
// reset: async active low; all entries invalid, ages oldest, used mask clear, no clearing pass
module lru_writeback_register_cache_top #(
  parameter int unsigned AGE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // var_id[9:0], imm_value[25:10], var_class[27:26], stack_slot[35:28], write[36], zero fill
  input  logic [39:0] s_axis_tdata_i,
  // command[0], is_variable[1]
  input  logic [1:0]  s_axis_tuser_i,
  // result channel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // reg_index[2:0], hit[3], load_valid[4], spill_valid[5], spill_var_id[15:6],
  // spill_class[17:16], spill_slot[25:18], spill_reg[28:26], used_mask[33:29], zero fill
  output logic [39:0] m_axis_tdata_o,
  // status[0]
  output logic [0:0]  m_axis_tuser_o,
  // last result beat of one request
  output logic        m_axis_tlast_o
);

  lrc_pkg::in_t  in_beat;
  lrc_pkg::res_t res;
  lrc_pkg::cmd_t cmd;
  lrc_pkg::sts_t sts;

  // unpack the request beat
  assign in_beat.command     = s_axis_tuser_i[0];
  assign in_beat.is_variable = s_axis_tuser_i[1];
  assign in_beat.var_id      = s_axis_tdata_i[9:0];
  assign in_beat.imm_value   = s_axis_tdata_i[25:10];
  assign in_beat.var_class   = s_axis_tdata_i[27:26];
  assign in_beat.stack_slot  = s_axis_tdata_i[35:28];
  assign in_beat.write       = s_axis_tdata_i[36];

  // sequencer: age pass, lookup/pick, flush walk
  lrc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_flush_i (s_axis_tuser_i[0]),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // entry store, tag compare, lru pick and output register
  lrc_dp #(
    .AGE_BITS (AGE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_beat),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res)
  );

  // pack the result beat
  assign m_axis_tdata_o = {6'b0, res.used_mask, res.spill_reg, res.spill_slot,
                           res.spill_class, res.spill_var_id, res.spill_valid,
                           res.load_valid, res.hit, res.reg_index};
  assign m_axis_tuser_o = res.status;
  assign m_axis_tlast_o = res.last;

endmodule
